// ===== hdl/gtg_pkg.sv =====
// ----------------------------------------------------------------------------
// gtg_pkg: shared types and constants for the go-to-goal speed command
// fixed-point widths, arctangent table and the stage payload struct
// ----------------------------------------------------------------------------
`default_nettype none

package gtg_pkg;

    // register indexes
    localparam logic [2:0] REG_TARGET_X  = 3'd0;
    localparam logic [2:0] REG_TARGET_Y  = 3'd1;
    localparam logic [2:0] REG_GAIN      = 3'd2;
    localparam logic [2:0] REG_MAX_SPEED = 3'd3;
    localparam logic [2:0] REG_DIST_TOL  = 3'd4;
    localparam logic [2:0] REG_ANG_TOL   = 3'd5;

    // cordic datapath widths: 17 bit delta shifted by 12, plus growth
    localparam int XY_W  = 32;
    localparam int Z_W   = 34;
    localparam int ATAN_LEN = 24;

    localparam logic signed [Z_W-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

    typedef logic [29:0] atan_t;

    function automatic atan_t atan_q30(input logic [4:0] idx);
        atan_t r;
        case (idx)
            5'd0:  r = 30'd843314857;
            5'd1:  r = 30'd497837829;
            5'd2:  r = 30'd263043837;
            5'd3:  r = 30'd133525159;
            5'd4:  r = 30'd67021687;
            5'd5:  r = 30'd33543516;
            5'd6:  r = 30'd16775851;
            5'd7:  r = 30'd8388437;
            5'd8:  r = 30'd4194283;
            5'd9:  r = 30'd2097149;
            5'd10: r = 30'd1048576;
            5'd11: r = 30'd524288;
            5'd12: r = 30'd262144;
            5'd13: r = 30'd131072;
            5'd14: r = 30'd65536;
            5'd15: r = 30'd32768;
            5'd16: r = 30'd16384;
            5'd17: r = 30'd8192;
            5'd18: r = 30'd4096;
            5'd19: r = 30'd2048;
            5'd20: r = 30'd1024;
            5'd21: r = 30'd512;
            5'd22: r = 30'd256;
            5'd23: r = 30'd128;
            default: r = '0;
        endcase
        return r;
    endfunction

    // per-stage cordic state
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
        logic signed [14:0]     heading;
    } cstage_t;

endpackage

`default_nettype wire

// ===== hdl/gtg_cordic_step.sv =====
// ----------------------------------------------------------------------------
// gtg_cordic_step: one registered vectoring cordic iteration
// shift-add micro-rotation with fixed shift amount, stallable
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_cordic_step #(
    parameter int STEP = 0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  gtg_pkg::cstage_t      in_data,
    output logic                  out_valid,
    output gtg_pkg::cstage_t      out_data
);
    import gtg_pkg::*;

    localparam logic [4:0] IDX = 5'(STEP);

    logic             valid_reg;
    cstage_t          data_reg;
    cstage_t          data_next;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  at;

    // micro-rotation toward the x axis
    always_comb
    begin
        xs = in_data.x >>> STEP;
        ys = in_data.y >>> STEP;
        at = Z_W'(atan_q30(IDX));
        data_next = in_data;
        if (!in_data.y[XY_W-1])
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + at;
        end
        else
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - at;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/go_to_goal_speed_command.sv =====
// Throughput: one pose per cycle unless stalled; the pipeline advances whenever the output
// register is empty or being taken, so a stall only holds every stage.
// Depth is set by the cordic chain, one micro-rotation per stage, plus stage 0, stages A to C and the output register.
// Reset: rst_n clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
// go_to_goal_speed_command: proportional go-to-goal controller
// pipelined vectoring cordic for distance and bearing, then the decision
// ----------------------------------------------------------------------------
`default_nettype none

module go_to_goal_speed_command #(
    parameter int CORDIC_STEPS = 14
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // pose stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // pos_x[15:0], pos_y[31:16], heading[46:32]
    // speed command stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // linear_speed[14:0], angular_speed[29:15]
);
    import gtg_pkg::*;

    localparam int NS = CORDIC_STEPS;

    // configuration registers
    logic signed [15:0] target_x_reg, target_y_reg;
    logic [15:0] gain_reg;
    logic [14:0] max_speed_reg, dist_tol_reg;
    logic [13:0] ang_tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg  <= 16'sd256;
            target_y_reg  <= 16'sd256;
            gain_reg      <= 16'd256;
            max_speed_reg <= 15'd768;
            dist_tol_reg  <= 15'd26;
            ang_tol_reg   <= 14'd819;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET_X:  target_x_reg  <= cfg_data;
                REG_TARGET_Y:  target_y_reg  <= cfg_data;
                REG_GAIN:      gain_reg      <= cfg_data;
                REG_MAX_SPEED: max_speed_reg <= cfg_data[14:0];
                REG_DIST_TOL:  dist_tol_reg  <= cfg_data[14:0];
                REG_ANG_TOL:   ang_tol_reg   <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // pipeline advances when the output register frees up
    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // stage 0: deltas and half-plane pre-rotation
    logic             v0_reg;
    cstage_t          s0_reg, s0_next;
    logic signed [16:0] dx, dy;
    logic signed [XY_W-1:0] xw, yw;

    always_comb
    begin
        dx = 17'(target_x_reg) - 17'($signed(s_axis_tdata[15:0]));
        dy = 17'(target_y_reg) - 17'($signed(s_axis_tdata[31:16]));
        xw = XY_W'(dx) <<< 12;
        yw = XY_W'(dy) <<< 12;
        s0_next.zero    = (dx == '0) && (dy == '0);
        s0_next.heading = $signed(s_axis_tdata[46:32]);
        s0_next.x = xw;
        s0_next.y = yw;
        s0_next.z = '0;
        if (dx[16])
        begin
            s0_next.x = -xw;
            s0_next.y = -yw;
            s0_next.z = dy[16] ? -PI_Q30 : PI_Q30;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s0_reg <= s0_next;
    end

    // cordic chain
    logic    cv [0:NS];
    cstage_t cd [0:NS];
    assign cv[0] = v0_reg;
    assign cd[0] = s0_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_step
        gtg_cordic_step #(.STEP(i)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cv[i]),
            .in_data   (cd[i]),
            .out_valid (cv[i+1]),
            .out_data  (cd[i+1])
        );
    end

    // stage A: scale by inverse gain, round bearing, form error
    logic        va_reg;
    logic [61:0] prod_reg;
    logic        zero_a_reg;
    logic signed [16:0] err_a_reg;
    logic [30:0] xpos;
    logic signed [Z_W-1:0] zr;
    logic signed [16:0] bear;

    always_comb
    begin
        xpos = cd[NS].x[XY_W-1] ? '0 : 31'(cd[NS].x);
        zr   = cd[NS].z + Z_W'(34'sd131072);
        bear = 17'(zr >>> 18);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= cv[NS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= 62'(xpos) * 62'(INV_GAIN_Q30);
            zero_a_reg <= cd[NS].zero;
            err_a_reg  <= bear - 17'(cd[NS].heading);
        end
    end

    // stage B: round distance, absolute error
    logic        vb_reg;
    logic [16:0] dist_b_reg;
    logic [14:0] aerr_b_reg;
    logic [61:0] dsum;
    logic [16:0] aerr;

    always_comb
    begin
        dsum = prod_reg + (62'd1 << 41);
        aerr = err_a_reg[16] ? 17'(-err_a_reg) : 17'(err_a_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (en)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_b_reg <= zero_a_reg ? '0 : dsum[58:42];
            aerr_b_reg <= aerr[14:0];
        end
    end

    // stage C: gain product and decisions
    logic        vc_reg;
    logic [32:0] lin_c_reg;
    logic        move_c_reg, turn_c_reg;
    logic [14:0] aerr_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (en)
            vc_reg <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_c_reg  <= 33'(gain_reg) * 33'(dist_b_reg);
            move_c_reg <= dist_b_reg > 17'(dist_tol_reg);
            turn_c_reg <= aerr_b_reg > 15'(ang_tol_reg);
            aerr_c_reg <= aerr_b_reg;
        end
    end

    // output register: clamp and select
    logic [24:0] lin_sh;
    logic [14:0] lin_sel, ang_sel;
    logic [31:0] out_reg;
    logic        out_v_reg;

    always_comb
    begin
        lin_sh  = lin_c_reg[32:8];
        lin_sel = '0;
        ang_sel = '0;
        if (move_c_reg)
        begin
            if (turn_c_reg)
                ang_sel = aerr_c_reg;
            else if (lin_sh > 25'(max_speed_reg))
                lin_sel = max_speed_reg;
            else
                lin_sel = lin_sh[14:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= vc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= {2'b00, ang_sel, lin_sel};
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_reg;

endmodule

`default_nettype wire

// ===== bench/go_to_goal_speed_command_tb.sv =====
// ----------------------------------------------------------------------------
// go_to_goal_speed_command_tb: self-checking bench for the go-to-goal block
// drives poses with random idling on both streams, predicts each speed
// command with a bit-accurate cordic model and compares beat by beat
// ----------------------------------------------------------------------------
`default_nettype none

module go_to_goal_speed_command_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gtg_pkg::*;

    localparam int STEPS = 14;
    localparam int LATENCY = STEPS + 5;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [14:0] angular;
        logic [14:0] linear;
    } speed_cmd_t;

    // controller settings shadowed for prediction
    logic signed [15:0] goal_x = 16'sd256;
    logic signed [15:0] goal_y = 16'sd256;
    logic [15:0] gain_q88 = 16'd256;
    logic [14:0] speed_cap = 15'd768;
    logic [14:0] dist_tol = 15'd26;
    logic [13:0] ang_tol = 14'd819;

    // bit-accurate prediction of one speed command
    function automatic speed_cmd_t predict_command(logic signed [15:0] px,
                                                   logic signed [15:0] py,
                                                   logic signed [14:0] hd);
        longint dx, dy, x, y, z, xs, ys, distance, bearing, err, aerr, lin;
        speed_cmd_t cmd;
        dx = longint'(goal_x) - longint'(px);
        dy = longint'(goal_y) - longint'(py);
        cmd = '0;
        distance = 0;
        bearing = 0;
        if (dx != 0 || dy != 0)
        begin
            x = dx <<< 12;
            y = dy <<< 12;
            z = 0;
            // left half plane: rotate by pi first
            if (x < 0)
            begin
                z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x += ys;
                    y -= xs;
                    z += longint'(atan_q30(i[4:0]));
                end
                else
                begin
                    x -= ys;
                    y += xs;
                    z -= longint'(atan_q30(i[4:0]));
                end
            end
            if (x < 0)
                x = 0;
            distance = (x * 64'd652032874 + (64'd1 << 41)) >>> 42;
            bearing = (z + (64'sd1 << 17)) >>> 18;
        end
        if (distance > longint'(dist_tol))
        begin
            err = bearing - longint'(hd);
            aerr = (err < 0) ? -err : err;
            if (aerr > longint'(ang_tol))
                cmd.angular = aerr[14:0];
            else
            begin
                lin = (longint'(gain_q88) * distance) >>> 8;
                if (lin > longint'(speed_cap))
                    lin = longint'(speed_cap);
                cmd.linear = lin[14:0];
            end
        end
        return cmd;
    endfunction

    // expected commands in order and mismatch bookkeeping
    class speed_scoreboard;
        speed_cmd_t pending_cmds[$];
        int errors = 0;

        function void note_pose(logic [47:0] beat);
            pending_cmds.push_back(predict_command(beat[15:0], beat[31:16], beat[46:32]));
        endfunction

        function void check_cmd(logic [31:0] beat);
            speed_cmd_t want, got;
            got = beat[29:0];
            if (pending_cmds.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected command beat %h", beat);
                return;
            end
            want = pending_cmds.pop_front();
            if (beat[31:30] != 2'b00 || got.linear != want.linear
                || got.angular != want.angular)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: linear exp %0d got %0d, angular exp %0d got %0d",
                             want.linear, got.linear, want.angular, got.angular);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;  // pos_x[15:0], pos_y[31:16], heading[46:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;       // linear_speed[14:0], angular_speed[29:15]

    int src_idle_pct = 17;
    int sink_idle_pct = 88;
    int quiet_cycles = 0;
    speed_scoreboard board = new();

    go_to_goal_speed_command #(.CORDIC_STEPS(STEPS)) dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // sink side: random stall, pose recording and result checking
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_cmd(m_axis_tdata);
        if (rst_n && s_axis_tvalid && s_axis_tready)
            board.note_pose(s_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_TARGET_X:  goal_x = val;
            REG_TARGET_Y:  goal_y = val;
            REG_GAIN:      gain_q88 = val;
            REG_MAX_SPEED: speed_cap = val[14:0];
            REG_DIST_TOL:  dist_tol = val[14:0];
            REG_ANG_TOL:   ang_tol = val[13:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // one pose beat, with optional idle cycles ahead of it
    // valid stays high after the beat so the next one can follow directly
    task automatic send_pose(input logic [15:0] px, input logic [15:0] py,
                             input logic [14:0] hd);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, hd, py, px};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // drop valid and hold off until every command has arrived
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending_cmds.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic random_poses(input int count);
        logic [15:0] px, py;
        logic [14:0] hd;
        for (int n = 0; n < count; n++)
        begin
            // mostly near the goal so all decisions show up
            if ($urandom_range(3) != 0)
            begin
                px = goal_x + 16'($signed($urandom_range(1024)) - 512);
                py = goal_y + 16'($signed($urandom_range(1024)) - 512);
            end
            else
            begin
                px = 16'($urandom);
                py = 16'($urandom);
            end
            hd = 15'($signed($urandom_range(25736)) - 12868);
            if ($urandom_range(9) == 0)
                hd = 15'($urandom);
            send_pose(px, py, hd);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed poses with reset settings
        send_pose(16'd256, 16'd256, 15'd0);
        send_pose(16'd260, 16'd250, 15'd0);
        send_pose(16'd1256, 16'd256, 15'd0);
        send_pose(16'd0, 16'd256, 15'd0);
        send_pose(16'd0, 16'd256, 15'd12868);
        send_pose(16'd0, 16'd512, 15'd12868);
        send_pose(16'd0, 16'd0, 15'd3217);
        send_pose(16'h8000, 16'h8000, 15'h4000);
        send_pose(16'h7fff, 16'h7fff, 15'h3fff);
        send_pose(16'h7fff, 16'h8000, 15'h7fff);
        send_pose(16'h8000, 16'h7fff, -15'sd12868);
        send_pose(16'd256, 16'd0, 15'd0);
        send_pose(16'd256, 16'd512, -15'sd6434);
        send_pose(16'd512, 16'd256, 15'h2000);
        send_pose(16'hffff, 16'hffff, 15'd0);
        drain();

        // extreme settings
        write_reg(REG_TARGET_X, 16'h7fff);
        write_reg(REG_TARGET_Y, 16'h8000);
        write_reg(REG_GAIN, 16'hffff);
        write_reg(REG_MAX_SPEED, 16'h7fff);
        write_reg(REG_DIST_TOL, 16'd0);
        write_reg(REG_ANG_TOL, 16'h3fff);
        write_reg(3'd7, 16'h1234);
        send_pose(16'h8000, 16'h7fff, 15'd0);
        send_pose(16'h7fff, 16'h8000, 15'd0);
        send_pose(16'h7ffe, 16'h8000, 15'd0);
        send_pose(16'h0000, 16'h0000, 15'd0);
        random_poses(200);
        drain();

        write_reg(REG_TARGET_X, 16'h8000);
        write_reg(REG_TARGET_Y, 16'h7fff);
        write_reg(REG_GAIN, 16'd0);
        write_reg(REG_MAX_SPEED, 16'd0);
        write_reg(REG_DIST_TOL, 16'h7fff);
        write_reg(REG_ANG_TOL, 16'd0);
        random_poses(200);
        drain();

        // swap idling pattern
        src_idle_pct = 88;
        sink_idle_pct = 17;
        write_reg(REG_TARGET_X, 16'($urandom));
        write_reg(REG_TARGET_Y, 16'($urandom));
        write_reg(REG_GAIN, 16'd640);
        write_reg(REG_MAX_SPEED, 16'd1500);
        write_reg(REG_DIST_TOL, 16'd40);
        write_reg(REG_ANG_TOL, 16'd12868);
        random_poses(400);
        drain();

        // no idling, mid settings
        src_idle_pct = 0;
        sink_idle_pct = 0;
        write_reg(REG_TARGET_X, 16'd256);
        write_reg(REG_TARGET_Y, 16'd256);
        write_reg(REG_GAIN, 16'd300);
        write_reg(REG_MAX_SPEED, 16'd768);
        write_reg(REG_DIST_TOL, 16'd26);
        write_reg(REG_ANG_TOL, 16'd819);
        random_poses(500);
        drain();

        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
